// File: sv/right_triangle_angles_macros.svh
// Assertion macros shared by the right triangle angle datapath.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef RIGHT_TRIANGLE_ANGLES_MACROS_SVH
`define RIGHT_TRIANGLE_ANGLES_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset.
`define RTA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("right_triangle_angles: implication check failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define RTA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("right_triangle_angles: next-cycle check failed");
`else
`define RTA_ASSERT_IMP(lbl, ante, cons)
`define RTA_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// File: sv/rta_pkg.sv
// Shared constants, types and the arctangent table of the right triangle angle block.
// No dependencies.
package rta_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int LEG_WIDTH_DEF    = 16;
    localparam int TABLE_LEN        = 24;
    localparam int Z_WIDTH          = 25;
    localparam int ANGLE_WIDTH      = 16;
    localparam int RIGHT_ANGLE_Q8   = 23040;
    localparam int ROUND_BIAS       = 128;
    localparam int FRAC_DROP        = 8;

    // Control bits that travel alongside each word down the cell row.
    typedef struct packed {
        logic valid;
        logic err;
    } rta_ctrl_t;

    // atan(2^-i) in degrees, 16 fractional bits, rounded to nearest.
    function automatic logic signed [Z_WIDTH-1:0] atan_entry(input int idx);
        logic signed [Z_WIDTH-1:0] val;
        begin
            case (idx)
                0:       val = 25'sd2949120;
                1:       val = 25'sd1740967;
                2:       val = 25'sd919879;
                3:       val = 25'sd466945;
                4:       val = 25'sd234379;
                5:       val = 25'sd117304;
                6:       val = 25'sd58666;
                7:       val = 25'sd29335;
                8:       val = 25'sd14668;
                9:       val = 25'sd7334;
                10:      val = 25'sd3667;
                11:      val = 25'sd1833;
                12:      val = 25'sd917;
                13:      val = 25'sd458;
                14:      val = 25'sd229;
                15:      val = 25'sd115;
                16:      val = 25'sd57;
                17:      val = 25'sd29;
                18:      val = 25'sd14;
                19:      val = 25'sd7;
                20:      val = 25'sd4;
                21:      val = 25'sd2;
                22:      val = 25'sd1;
                default: val = 25'sd0;
            endcase
            return val;
        end
    endfunction

endpackage

// File: sv/rta_cell.sv
// One CORDIC vectoring micro-rotation, registered; one cell in the cell row of the angle block.
// Depends on rta_pkg and right_triangle_angles_macros.svh.
`include "right_triangle_angles_macros.svh"

module rta_cell #(
    parameter int STAGE = 0,
    parameter int DW    = 35
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  rta_pkg::rta_ctrl_t                ctrl_in,
    input  logic signed [DW-1:0]              x_in,
    input  logic signed [DW-1:0]              y_in,
    input  logic signed [rta_pkg::Z_WIDTH-1:0] z_in,
    output rta_pkg::rta_ctrl_t                ctrl_out,
    output logic signed [DW-1:0]              x_out,
    output logic signed [DW-1:0]              y_out,
    output logic signed [rta_pkg::Z_WIDTH-1:0] z_out
);
    import rta_pkg::*;

    localparam logic signed [Z_WIDTH-1:0] ANGLE_STEP = atan_entry(STAGE);

    logic signed [DW-1:0]      xs;
    logic signed [DW-1:0]      ys;
    logic signed [DW-1:0]      x_next;
    logic signed [DW-1:0]      y_next;
    logic signed [Z_WIDTH-1:0] z_next;
    rta_ctrl_t                 ctrl_reg;
    logic signed [DW-1:0]      x_reg;
    logic signed [DW-1:0]      y_reg;
    logic signed [Z_WIDTH-1:0] z_reg;

    // Arithmetic shifts round toward minus infinity, as the rotation needs.
    assign xs = x_in >>> STAGE;
    assign ys = y_in >>> STAGE;

    always_comb
    begin
        if (!y_in[DW-1])
        begin
            x_next = x_in + ys;
            y_next = y_in - xs;
            z_next = z_in + ANGLE_STEP;
        end
        else
        begin
            x_next = x_in - ys;
            y_next = y_in + xs;
            z_next = z_in - ANGLE_STEP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else
        begin
            ctrl_reg <= ctrl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign ctrl_out = ctrl_reg;
    assign x_out    = x_reg;
    assign y_out    = y_reg;
    assign z_out    = z_reg;

    // A word entering the cell leaves it in the next cycle.
    `RTA_ASSERT_NXT(a_cell_advance, ctrl_in.valid, ctrl_out.valid && ctrl_out.err == $past(ctrl_in.err))
    // The x coordinate never shrinks, so it stays non-negative for a valid word.
    `RTA_ASSERT_IMP(a_cell_x_pos, ctrl_out.valid && !ctrl_out.err, !x_out[DW-1])
    // The flag of a zero leg passes through untouched.
    `RTA_ASSERT_NXT(a_cell_err_keep, ctrl_in.valid && ctrl_in.err, ctrl_out.err)

endmodule

// File: sv/rta_post.sv
// Output stage: rounds the angle accumulator to Q8.8, saturates, and forms both angles.
// Depends on rta_pkg.
module rta_post (
    input  logic                               clk,
    input  logic                               rst_n,
    input  rta_pkg::rta_ctrl_t                 ctrl_in,
    input  logic signed [rta_pkg::Z_WIDTH-1:0] z_in,
    output logic                               done,
    output logic [rta_pkg::ANGLE_WIDTH-1:0]    angle_a,
    output logic [rta_pkg::ANGLE_WIDTH-1:0]    angle_b,
    output logic                               status
);
    import rta_pkg::*;

    localparam int QW = Z_WIDTH - FRAC_DROP;
    localparam logic signed [QW-1:0] Q_MAX = QW'(RIGHT_ANGLE_Q8);
    localparam logic signed [QW-1:0] Q_MIN = -QW'(RIGHT_ANGLE_Q8);

    logic signed [Z_WIDTH-1:0]  z_biased;
    logic signed [QW-1:0]       q_round;
    logic signed [QW-1:0]       q_sat;
    logic [ANGLE_WIDTH-1:0]     angle_a_next;
    logic [ANGLE_WIDTH-1:0]     angle_b_next;
    logic                       done_reg;
    logic [ANGLE_WIDTH-1:0]     angle_a_reg;
    logic [ANGLE_WIDTH-1:0]     angle_b_reg;
    logic                       status_reg;

    // The accumulator stays within about 100 degrees, so the bias cannot overflow.
    assign z_biased = z_in + Z_WIDTH'(ROUND_BIAS);
    assign q_round  = QW'(z_biased >>> FRAC_DROP);

    always_comb
    begin
        if (q_round > Q_MAX)
        begin
            q_sat = Q_MAX;
        end
        else if (q_round < Q_MIN)
        begin
            q_sat = Q_MIN;
        end
        else
        begin
            q_sat = q_round;
        end

        if (ctrl_in.err)
        begin
            angle_a_next = '0;
            angle_b_next = '0;
        end
        else
        begin
            angle_a_next = ANGLE_WIDTH'(q_sat);
            angle_b_next = ANGLE_WIDTH'(RIGHT_ANGLE_Q8) - ANGLE_WIDTH'(q_sat);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctrl_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        angle_a_reg <= angle_a_next;
        angle_b_reg <= angle_b_next;
        status_reg  <= ctrl_in.err;
    end

    assign done    = done_reg;
    assign angle_a = angle_a_reg;
    assign angle_b = angle_b_reg;
    assign status  = status_reg;

endmodule

// File: sv/right_triangle_angles.sv
// Top level of the right triangle angle block: input register, CORDIC cell row, output stage.
// Depends on rta_pkg, rta_cell, rta_post and right_triangle_angles_macros.svh.
//
// Usage:
// A word holding the two legs leg_a and leg_b is accepted at each rising clock
// edge where start is high and busy is low. The datapath is a fully pipelined
// row of CORDIC_STEPS vectoring cells, so busy is always low and a new word
// may be offered in every cycle; the throughput is one word per clock.
// The result word (angle_a, angle_b, status) appears on the outputs for exactly
// one cycle, marked by done, after it has passed the input register, the
// register of each cell and the output stage register, in that order. The output
// stage holds it for that single cycle, and it is taken at the edge that ends it.
// The receiver cannot stall the block; it must take each result word in the
// cycle that done is high. Results come out in the order words went in.
// If either leg is zero, status is set and both angles read zero.
// Asynchronous reset (rst_n low) empties the pipeline: every word in flight is
// dropped and done stays low until new words have passed through the row.
`include "right_triangle_angles_macros.svh"

module right_triangle_angles #(
    parameter int CORDIC_STEPS = rta_pkg::CORDIC_STEPS_DEF,
    parameter int LEG_WIDTH    = rta_pkg::LEG_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [LEG_WIDTH-1:0]        leg_a,
    input  logic signed [LEG_WIDTH-1:0]        leg_b,
    output logic                               done,
    output logic [rta_pkg::ANGLE_WIDTH-1:0]    angle_a,
    output logic [rta_pkg::ANGLE_WIDTH-1:0]    angle_b,
    output logic                               status
);
    import rta_pkg::*;

    // Room for the pre-scaled legs plus the CORDIC gain and the |b| extension.
    localparam int DW = LEG_WIDTH + CORDIC_STEPS + 3;
    localparam logic signed [ANGLE_WIDTH-1:0] RIGHT_Q8 = ANGLE_WIDTH'(RIGHT_ANGLE_Q8);

    logic                      accept;
    logic signed [DW-1:0]      a_ext;
    logic signed [DW-1:0]      b_ext;
    logic signed [DW-1:0]      b_mag;
    rta_ctrl_t                 ctrl0_next;
    rta_ctrl_t                 ctrl0_reg;
    logic signed [DW-1:0]      x0_reg;
    logic signed [DW-1:0]      y0_reg;
    logic signed [ANGLE_WIDTH-1:0] angle_a_s;

    rta_ctrl_t                 ctrl_pipe [0:CORDIC_STEPS];
    logic signed [DW-1:0]      x_pipe    [0:CORDIC_STEPS];
    logic signed [DW-1:0]      y_pipe    [0:CORDIC_STEPS];
    logic signed [Z_WIDTH-1:0] z_pipe    [0:CORDIC_STEPS];

    // The pipeline never blocks, so a word is taken whenever start is high.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Legs are widened before the magnitude is taken so the most negative value survives.
    assign a_ext = DW'(leg_a);
    assign b_ext = DW'(leg_b);
    assign b_mag = b_ext[DW-1] ? -b_ext : b_ext;

    always_comb
    begin
        ctrl0_next.valid = accept;
        ctrl0_next.err   = (leg_a == '0) || (leg_b == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl0_reg <= '0;
        end
        else
        begin
            ctrl0_reg <= ctrl0_next;
        end
    end

    // The legs are scaled up by 2^CORDIC_STEPS so the small shifts keep their bits.
    always_ff @(posedge clk)
    begin
        x0_reg <= b_mag <<< CORDIC_STEPS;
        y0_reg <= a_ext <<< CORDIC_STEPS;
    end

    assign ctrl_pipe[0] = ctrl0_reg;
    assign x_pipe[0]    = x0_reg;
    assign y_pipe[0]    = y0_reg;
    assign z_pipe[0]    = '0;

    // One cell per micro-rotation; each hands its word to the next every cycle.
    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cell
        rta_cell #(
            .STAGE (i),
            .DW    (DW)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl_in  (ctrl_pipe[i]),
            .x_in     (x_pipe[i]),
            .y_in     (y_pipe[i]),
            .z_in     (z_pipe[i]),
            .ctrl_out (ctrl_pipe[i+1]),
            .x_out    (x_pipe[i+1]),
            .y_out    (y_pipe[i+1]),
            .z_out    (z_pipe[i+1])
        );
    end

    // Rounding, saturation and the complementary angle are formed here.
    rta_post u_post (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl_in (ctrl_pipe[CORDIC_STEPS]),
        .z_in    (z_pipe[CORDIC_STEPS]),
        .done    (done),
        .angle_a (angle_a),
        .angle_b (angle_b),
        .status  (status)
    );

    // Angle A read as a signed value for the range check.
    assign angle_a_s = angle_a;

    // A flagged word carries zero angles.
    `RTA_ASSERT_IMP(a_err_zero, done && status, angle_a == '0 && angle_b == '0)
    // The two acute angles always add up to a right angle for a good word.
    `RTA_ASSERT_IMP(a_sum_right, done && !status, ANGLE_WIDTH'(angle_a + angle_b) == RIGHT_Q8)
    // Angle A stays within plus or minus ninety degrees.
    `RTA_ASSERT_IMP(a_range, done && !status, angle_a_s <= RIGHT_Q8 && angle_a_s >= -RIGHT_Q8)

endmodule

// File: sim/right_triangle_angles_test.sv
// Self-checking testbench for right_triangle_angles: directed and random leg pairs,
// checked word by word against a CORDIC angle predictor kept in a small ledger class.
// Depends on rta_pkg and the right_triangle_angles RTL.
`timescale 1ns / 100ps

// One result word as the block presents it.
typedef struct {
    logic [15:0] angle_a;
    logic [15:0] angle_b;
    logic        status;
} angle_word_t;

// Predicts the angles for every accepted leg pair and checks result words in order.
class angle_ledger;
    localparam int STEPS    = rta_pkg::CORDIC_STEPS_DEF;
    localparam int TAB_LEN  = 24;
    localparam longint RIGHT_Q8 = 23040;

    // atan(2^-i) in degrees with 16 fractional bits.
    longint atan_q16 [TAB_LEN] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    angle_word_t owed_angles[$];
    int          mismatches = 0;

    function automatic angle_word_t angles_of(logic signed [15:0] a_in,
                                              logic signed [15:0] b_in);
        angle_word_t w;
        longint      a, b, x, y, z, q, xs, ys;
        begin
            a = a_in;
            b = b_in;
            if (a == 0 || b == 0)
            begin
                w.angle_a = '0;
                w.angle_b = '0;
                w.status  = 1'b1;
                return w;
            end
            // Vectoring mode: rotate (|b|, a) onto the x axis and sum the angles.
            x = (b < 0 ? -b : b) <<< STEPS;
            y = a <<< STEPS;
            z = 0;
            for (int i = 0; i < STEPS && i < TAB_LEN; i++)
            begin
                xs = x >>> i;
                ys = y >>> i;
                if (y >= 0)
                begin
                    x = x + ys;
                    y = y - xs;
                    z = z + atan_q16[i];
                end
                else
                begin
                    x = x - ys;
                    y = y + xs;
                    z = z - atan_q16[i];
                end
            end
            q = (z + 128) >>> 8;
            if (q > RIGHT_Q8)
                q = RIGHT_Q8;
            if (q < -RIGHT_Q8)
                q = -RIGHT_Q8;
            w.angle_a = 16'(q);
            w.angle_b = 16'(RIGHT_Q8 - q);
            w.status  = 1'b0;
            return w;
        end
    endfunction

    function void note_legs(logic signed [15:0] a, logic signed [15:0] b);
        owed_angles.push_back(angles_of(a, b));
    endfunction

    function int owed();
        return owed_angles.size();
    endfunction

    task report(string what, longint got, longint want);
        $display("mismatch: %s got %0d expected %0d", what, got, want);
        mismatches++;
    endtask

    task check_angles(logic [15:0] angle_a, logic [15:0] angle_b, logic status);
        angle_word_t w;
        if (owed_angles.size() == 0)
        begin
            report("result word with none owed, angle_a", angle_a, 0);
            return;
        end
        w = owed_angles.pop_front();
        if (angle_a !== w.angle_a)
            report("angle_a", $signed(angle_a), $signed(w.angle_a));
        if (angle_b !== w.angle_b)
            report("angle_b", angle_b, w.angle_b);
        if (status !== w.status)
            report("status", status, w.status);
    endtask
endclass

module right_triangle_angles_test;

    localparam int STEPS    = rta_pkg::CORDIC_STEPS_DEF;
    localparam int LEG_W    = rta_pkg::LEG_WIDTH_DEF;
    // Input register, one cell per step and the output stage.
    localparam int LATENCY  = STEPS + 2;
    // Longest quiet stretch of a correct run is a long sender gap or a
    // full drain; the limit is several times that.
    localparam int QUIET_LIMIT  = 500;
    localparam int RANDOM_WORDS = 1650;

    logic                    clk   = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    start = 1'b0;
    logic signed [LEG_W-1:0] leg_a = '0;
    logic signed [LEG_W-1:0] leg_b = '0;
    logic                    busy;
    logic                    done;
    logic [15:0]             angle_a;
    logic [15:0]             angle_b;
    logic                    status;

    angle_ledger ledger = new();
    int          quiet_cycles = 0;

    right_triangle_angles #(
        .CORDIC_STEPS(STEPS),
        .LEG_WIDTH   (LEG_W)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .leg_a  (leg_a),
        .leg_b  (leg_b),
        .done   (done),
        .angle_a(angle_a),
        .angle_b(angle_b),
        .status (status)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // The monitor samples at the rising edge, before any of the nonblocking
    // updates of that edge land, so it sees exactly what the block sampled.
    // An input word is noted before a result is checked; the path from input
    // to output is registered, so a word never meets its own result here.
    // The watchdog counts cycles in which neither side moved a word.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                ledger.note_legs(leg_a, leg_b);
            if (done)
                ledger.check_angles(angle_a, angle_b, status);
            if ((start && !busy) || done)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("right_triangle_angles regression: fail");
                $finish;
            end
        end
    end

    // Offers one word and returns at the edge that accepted it. The start
    // line is only raised here, so back-to-back words keep it high.
    task automatic send_word(input logic signed [LEG_W-1:0] a,
                             input logic signed [LEG_W-1:0] b);
        leg_a <= a;
        leg_b <= b;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Drops start and idles for the gap given by n; n of zero leaves start alone.
    task automatic idle(input int n);
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Holds the sender off until every owed result word has come back.
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (ledger.owed() != 0)
            @(posedge clk);
    endtask

    // Gap lengths: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 9);
        return $urandom_range(20, 60);
    endfunction

    // Picks one extreme leg value.
    function automatic logic signed [LEG_W-1:0] extreme_leg();
        case ($urandom_range(0, 5))
            0:       return -16'sd32768;
            1:       return -16'sd32767;
            2:       return -16'sd1;
            3:       return 16'sd1;
            4:       return 16'sd32766;
            default: return 16'sd32767;
        endcase
    endfunction

    // Small nonzero leg of random sign.
    function automatic logic signed [LEG_W-1:0] tiny_leg();
        logic signed [LEG_W-1:0] v;
        v = LEG_W'($urandom_range(1, 16));
        return $urandom_range(0, 1) ? -v : v;
    endfunction

    // Leg pairs that cover the edges named for the block: zero legs, the
    // most negative value, negative legs of either side and the near-90-degree
    // region where the CORDIC residue can overshoot and saturate.
    task automatic directed_words();
        logic signed [LEG_W-1:0] da [20] = '{
            16'sd0, 16'sd0, 16'sd5, 16'sd32767, -16'sd32768, 16'sd32767, 16'sd1,
            -16'sd32768, 16'sd1, -16'sd1, 16'sd1, -16'sd32768, 16'sd32767,
            16'sd100, -16'sd100, 16'sd0, -16'sd32768, 16'sd1, 16'sd12345,
            -16'sd32767
        };
        logic signed [LEG_W-1:0] db [20] = '{
            16'sd0, 16'sd5, 16'sd0, 16'sd32767, -16'sd32768, 16'sd1, 16'sd32767,
            16'sd1, -16'sd32768, -16'sd1, 16'sd1, 16'sd32767, -16'sd32768,
            -16'sd100, 16'sd100, -16'sd32768, 16'sd0, -16'sd1, -16'sd6789,
            -16'sd1
        };
        for (int i = 0; i < 20; i++)
        begin
            send_word(da[i], db[i]);
            idle(i % 3 == 2 ? $urandom_range(1, 4) : 0);
        end
    endtask

    // Random leg pairs: mostly uniform over all bits, with a share of small,
    // zero, extreme and very lopsided pairs.
    task automatic random_words();
        logic signed [LEG_W-1:0] a;
        logic signed [LEG_W-1:0] b;
        int                      kind;
        bit                      steady;
        steady = 1'b0;
        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            // Every hundred words decide whether this stretch runs gap-free.
            if (i % 100 == 0)
                steady = ($urandom_range(0, 3) == 0);
            kind = $urandom_range(0, 99);
            a = LEG_W'($urandom);
            b = LEG_W'($urandom);
            if (kind < 70)
            begin
            end
            else if (kind < 78)
            begin
                a = tiny_leg();
                b = tiny_leg();
            end
            else if (kind < 84)
            begin
                if ($urandom_range(0, 1))
                    a = '0;
                else
                    b = '0;
            end
            else if (kind < 90)
            begin
                a = extreme_leg();
                b = extreme_leg();
            end
            else if (kind < 95)
                b = tiny_leg();
            else
                a = tiny_leg();
            send_word(a, b);
            if ($urandom_range(0, 149) == 0)
                drain();
            else if (!steady)
                idle(pick_gap());
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed_words();
        // The sender waits here until the pipeline has given back every word.
        drain();
        random_words();
        drain();
        repeat (LATENCY + 4) @(posedge clk);
        if (ledger.mismatches == 0 && ledger.owed() == 0)
            $display("right_triangle_angles regression: pass");
        else
            $display("right_triangle_angles regression: fail");
        $finish;
    end

endmodule
